@@ hdl/rrs_pkg.sv @@
// shared types and constants for the round robin schedule simulator
// used by rrs_alu, rrs_table and round_robin_schedule_simulator
package rrs_pkg;

	localparam int MAX_PROCS_DEF = 64;
	localparam int ID_W          = 16;
	localparam int TIME_W        = 24;
	localparam int VAL_W         = 16;
	localparam int EV_W          = 3;
	localparam int KIND_W        = 2;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [EV_W-1:0] EV_SLICE   = 3'd0;
	localparam logic [EV_W-1:0] EV_IDLE    = 3'd1;
	localparam logic [EV_W-1:0] EV_ALLDONE = 3'd2;
	localparam logic [EV_W-1:0] EV_LOADED  = 3'd3;
	localparam logic [EV_W-1:0] EV_FULL    = 3'd4;
	localparam logic [EV_W-1:0] EV_CLEARED = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SLICE,
		ST_ADVANCE,
		ST_TURN,
		ST_WAIT
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] arrival;
		logic [VAL_W-1:0] burst;
		logic [VAL_W-1:0] remaining;
	} row_t;

endpackage

@@ hdl/round_robin_schedule_simulator.sv @@
// Round robin schedule simulator. A load, clear or step command is taken when start is high
// and busy is low; its single result appears on the result ports in the cycle after the
// command finishes, for exactly one cycle, flagged by result_valid, and cannot be held off.
// Load and clear finish in the accepting cycle. A step scans the process table from the
// saved position, one entry per cycle through the table's single read port, checking each
// registered entry as it arrives, and rescans once from the top when the previous pass ran
// something. A slice then uses the shared adder in ST_SLICE (slice length) and ST_ADVANCE
// (new time), and in ST_TURN (turnaround) and ST_WAIT (waiting) when the process finishes.
// A step with everything finished is answered without going busy.
// The quantum may be written only while busy is low and no command is in flight.
// depends on rrs_pkg, rrs_alu and rrs_table
module round_robin_schedule_simulator #(
	parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rrs_pkg::KIND_W-1:0]    kind,
	input  logic [rrs_pkg::ID_W-1:0]      process_id,
	input  logic [rrs_pkg::VAL_W-1:0]     burst_len,
	input  logic [rrs_pkg::VAL_W-1:0]     arrival_tick,
	input  logic                          quantum_we,
	input  logic [rrs_pkg::VAL_W-1:0]     quantum_wdata,
	output logic                          result_valid,
	output logic [rrs_pkg::EV_W-1:0]      event_res,
	output logic [rrs_pkg::ID_W-1:0]      run_id,
	output logic [rrs_pkg::TIME_W-1:0]    slice_start,
	output logic [rrs_pkg::TIME_W-1:0]    slice_end,
	output logic                          finished,
	output logic [rrs_pkg::TIME_W-1:0]    turnaround,
	output logic [rrs_pkg::TIME_W-1:0]    wait_total
);
	import rrs_pkg::*;

	localparam int IW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCS);

	state_t state_q, state_d;

	logic [VAL_W-1:0]  quantum_q;
	logic [VAL_W-1:0]  q_eff;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     done_q;
	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     rd_idx_q;
	logic [IW-1:0]     chk_idx_q;
	logic              chk_vld_q;
	logic              pass_ran_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] start_q;
	logic [VAL_W-1:0]  run_q;
	logic [VAL_W-1:0]  rem_new_q;
	logic [TIME_W-1:0] ta_q;

	logic              accept;
	logic              full;
	logic              all_done;
	logic              more;
	logic              hit;
	logic              le;
	logic [TIME_W-1:0] sat_sum;
	logic [TIME_W-1:0] sat_diff;

	alu_op_t           alu_op;
	logic [TIME_W-1:0] alu_a;
	logic [TIME_W-1:0] alu_b;
	logic [TIME_W:0]   alu_res;

	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	row_t              wr_row;
	logic              rd_en;
	row_t              rd_row;

	logic              res_valid_q;
	logic [EV_W-1:0]   ev_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] s_q;
	logic [TIME_W-1:0] e_q;
	logic              fin_q;
	logic [TIME_W-1:0] tat_q;
	logic [TIME_W-1:0] wt_q;

	rrs_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	rrs_table #(
		.DEPTH (MAX_PROCS),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[IW-1:0]),
		.rd_row  (rd_row)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == FULL_CNT);
	assign all_done = (done_q >= count_q);
	assign more     = (rd_idx_q < count_q);
	assign q_eff    = (quantum_q == '0) ? VAL_W'(1) : quantum_q;
	assign hit      = chk_vld_q && ({8'd0, rd_row.arrival} <= now_q)
	                  && (rd_row.remaining != '0);
	// remaining fits in this slice when remaining - quantum <= 0
	assign le       = alu_res[TIME_W] || (alu_res[TIME_W-1:0] == '0);
	assign sat_sum  = alu_res[TIME_W] ? {TIME_W{1'b1}} : alu_res[TIME_W-1:0];
	assign sat_diff = alu_res[TIME_W] ? '0 : alu_res[TIME_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_STEP && !all_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (hit) begin
					state_d = ST_SLICE;
				end else if (more || pass_ran_q) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SLICE:   state_d = ST_ADVANCE;
			ST_ADVANCE: state_d = (rem_new_q == '0) ? ST_TURN : ST_IDLE;
			ST_TURN:    state_d = ST_WAIT;
			ST_WAIT:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		alu_op  = ALU_ADD;
		alu_a   = now_q;
		alu_b   = TIME_W'(1);
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = chk_idx_q;
		wr_row  = '{id: rd_row.id, arrival: rd_row.arrival, burst: rd_row.burst,
		            remaining: rem_new_q};
		unique case (state_q)
			ST_IDLE: begin
				wr_en   = accept && kind == KIND_LOAD && !full;
				wr_addr = count_q[IW-1:0];
				wr_row  = '{id: process_id, arrival: arrival_tick,
				            burst: (burst_len == '0) ? VAL_W'(1) : burst_len,
				            remaining: (burst_len == '0) ? VAL_W'(1) : burst_len};
			end
			ST_SCAN: begin
				rd_en = !hit && more;
			end
			ST_SLICE: begin
				alu_op = ALU_SUB;
				alu_a  = TIME_W'(rd_row.remaining);
				alu_b  = TIME_W'(q_eff);
			end
			ST_ADVANCE: begin
				alu_b = TIME_W'(run_q);
				wr_en = 1'b1;
			end
			ST_TURN: begin
				alu_op = ALU_SUB;
				alu_b  = TIME_W'(rd_row.arrival);
			end
			ST_WAIT: begin
				alu_op = ALU_SUB;
				alu_a  = ta_q;
				alu_b  = TIME_W'(rd_row.burst);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quantum_q   <= VAL_W'(1);
			count_q     <= '0;
			done_q      <= '0;
			scan_q      <= '0;
			rd_idx_q    <= '0;
			chk_vld_q   <= 1'b0;
			pass_ran_q  <= 1'b0;
			now_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= 1'b0;
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_LOAD: begin
								res_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							KIND_CLEAR: begin
								res_valid_q <= 1'b1;
								count_q     <= '0;
								done_q      <= '0;
								now_q       <= '0;
								scan_q      <= '0;
								pass_ran_q  <= 1'b0;
							end
							KIND_STEP: begin
								res_valid_q <= all_done;
								rd_idx_q    <= scan_q;
								chk_vld_q   <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					priority if (hit) begin
						chk_vld_q <= 1'b1;
					end else if (more) begin
						rd_idx_q  <= rd_idx_q + CW'(1);
						chk_vld_q <= 1'b1;
					end else if (pass_ran_q) begin
						// something ran last pass: rescan from the top
						pass_ran_q <= 1'b0;
						scan_q     <= '0;
						rd_idx_q   <= '0;
						chk_vld_q  <= 1'b0;
					end else begin
						pass_ran_q  <= 1'b0;
						scan_q      <= '0;
						now_q       <= sat_sum;
						res_valid_q <= 1'b1;
					end
				end
				ST_ADVANCE: begin
					now_q      <= sat_sum;
					pass_ran_q <= 1'b1;
					scan_q     <= CW'(chk_idx_q) + CW'(1);
					if (rem_new_q == '0) begin
						done_q <= done_q + CW'(1);
					end else begin
						res_valid_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					res_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				id_q  <= '0;
				s_q   <= '0;
				e_q   <= '0;
				fin_q <= 1'b0;
				tat_q <= '0;
				wt_q  <= '0;
				priority if (kind == KIND_LOAD) begin
					ev_q <= full ? EV_FULL : EV_LOADED;
				end else if (kind == KIND_CLEAR) begin
					ev_q <= EV_CLEARED;
				end else begin
					ev_q <= EV_ALLDONE;
				end
			end
			ST_SCAN: begin
				if (rd_en) begin
					chk_idx_q <= rd_idx_q[IW-1:0];
				end
				ev_q  <= EV_IDLE;
				id_q  <= '0;
				s_q   <= now_q;
				e_q   <= sat_sum;
				fin_q <= 1'b0;
				tat_q <= '0;
				wt_q  <= '0;
			end
			ST_SLICE: begin
				start_q   <= now_q;
				run_q     <= le ? rd_row.remaining : q_eff;
				rem_new_q <= le ? '0 : alu_res[VAL_W-1:0];
			end
			ST_ADVANCE: begin
				ev_q  <= EV_SLICE;
				id_q  <= rd_row.id;
				s_q   <= start_q;
				e_q   <= sat_sum;
				fin_q <= 1'b0;
				tat_q <= '0;
				wt_q  <= '0;
			end
			ST_TURN: begin
				ta_q <= sat_diff;
			end
			ST_WAIT: begin
				fin_q <= 1'b1;
				tat_q <= ta_q;
				wt_q  <= sat_diff;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign event_res    = ev_q;
	assign run_id       = id_q;
	assign slice_start  = s_q;
	assign slice_end    = e_q;
	assign finished     = fin_q;
	assign turnaround   = tat_q;
	assign wait_total   = wt_q;

	// every result is given on the way back to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result given while a command is still in flight");

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= count_q)
		else $error("finished count exceeds table size");

	a_step_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_STEP) |=> (busy || result_valid))
		else $error("step transaction dropped");

	a_fin_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && finished) |-> (event_res == EV_SLICE))
		else $error("finished flag on a non-slice event");

endmodule

@@ hdl/rrs_alu.sv @@
// shared add / subtract unit for time and slice arithmetic
// depends on rrs_pkg; bit TIME_W of the result is the carry or borrow
module rrs_alu (
	input  rrs_pkg::alu_op_t             op,
	input  logic [rrs_pkg::TIME_W-1:0]   a,
	input  logic [rrs_pkg::TIME_W-1:0]   b,
	output logic [rrs_pkg::TIME_W:0]     res
);
	import rrs_pkg::*;

	always_comb begin
		unique case (op)
			ALU_ADD: res = {1'b0, a} + {1'b0, b};
			ALU_SUB: res = {1'b0, a} - {1'b0, b};
			default: res = '0;
		endcase
	end

endmodule

@@ hdl/rrs_table.sv @@
// process table memory: one write port, one read port with registered data
// depends on rrs_pkg for the row layout
module rrs_table #(
	parameter int DEPTH = rrs_pkg::MAX_PROCS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rrs_pkg::row_t   wr_row,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output rrs_pkg::row_t   rd_row
);
	import rrs_pkg::*;

	row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= mem[rd_addr];
		end
	end

endmodule
